// File: rtl/qft_pkg.sv
// Shared types and constants for the quoted field tokenizer.
`default_nettype none

package qft_pkg;

    // Position counter width and result field width
    localparam int unsigned POS_BITS   = 16;
    localparam int unsigned FIELD_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Scan mode codes
    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_PLAIN   = 2'd1;
    localparam logic [1:0] MODE_QUOTED  = 2'd2;
    localparam logic [1:0] MODE_ESCAPE  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // One captured input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } qft_item_t;

    // One result item
    typedef struct packed {
        logic [FIELD_BITS-1:0] field_start;
        logic [FIELD_BITS-1:0] field_length;
        logic                  text_done;
        logic                  position_overflow;
    } qft_result_t;

endpackage : qft_pkg

`default_nettype wire

// File: rtl/qft_in_stage.sv
// Input register stage: capture one item and hold it until the scanner takes it.
`default_nettype none

module qft_in_stage
    import qft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       advance,
    output logic            item_valid,
    output qft_item_t       item
);

    logic      valid_reg;
    logic      valid_next;
    qft_item_t item_reg;

    // Take a new item whenever the slot is empty or being drained
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.text_byte   <= text_byte;
            item_reg.end_of_text <= end_of_text;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule : qft_in_stage

`default_nettype wire

// File: rtl/qft_scan.sv
// Scanner: field mode, position counter and result formation for one item.
`default_nettype none

module qft_scan
    import qft_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire qft_item_t  item,
    input  wire logic       out_free,
    output logic            advance,
    output logic            res_load,
    output qft_result_t     res
);

    logic [1:0]          mode_reg;
    logic [1:0]          mode_next;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [POS_BITS-1:0] start_reg;
    logic [POS_BITS-1:0] start_next;
    logic [POS_BITS-1:0] last_reg;
    logic [POS_BITS-1:0] last_next;

    logic                at_limit;
    logic                is_space;
    logic                is_comma;
    logic                is_quote;
    logic                is_bslash;
    logic                emit;
    logic [POS_BITS:0]   len_wide;
    logic [POS_BITS-1:0] len_sat;

    assign at_limit  = (pos_reg == POS_MAX);
    assign is_space  = (item.text_byte == CH_SPACE);
    assign is_comma  = (item.text_byte == CH_COMMA);
    assign is_quote  = (item.text_byte == CH_QUOTE);
    assign is_bslash = (item.text_byte == CH_BSLASH);

    // Trimmed length of the open field, saturated at the counter limit
    always_comb
    begin
        len_wide = {1'b0, last_reg} - {1'b0, start_reg} + {{POS_BITS{1'b0}}, 1'b1};
        if (last_reg < start_reg)
        begin
            len_sat = '0;
        end
        else if (len_wide[POS_BITS])
        begin
            len_sat = POS_MAX;
        end
        else
        begin
            len_sat = len_wide[POS_BITS-1:0];
        end
    end

    // Result forms on end of text, or on an unquoted comma in a plain field
    assign emit     = item.end_of_text || ((mode_reg == MODE_PLAIN) && is_comma);
    assign advance  = item_valid && (out_free || !emit);
    assign res_load = advance && emit;

    // Build the result item
    always_comb
    begin
        if (item.end_of_text && (mode_reg == MODE_BETWEEN))
        begin
            res.field_start  = '0;
            res.field_length = '0;
        end
        else
        begin
            res.field_start  = FIELD_BITS'(start_reg);
            res.field_length = FIELD_BITS'(len_sat);
        end
        res.text_done         = item.end_of_text;
        res.position_overflow = item.end_of_text ? ovf_reg : (ovf_reg || at_limit);
    end

    // Next state for the scanner
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        start_next = start_reg;
        last_next  = last_reg;
        if (item.end_of_text)
        begin
            mode_next = MODE_BETWEEN;
            pos_next  = '0;
            ovf_next  = 1'b0;
        end
        else
        begin
            // Advance position, saturating at the limit
            if (at_limit)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + {{(POS_BITS-1){1'b0}}, 1'b1};
            end
            unique case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (!is_space && !is_comma)
                    begin
                        start_next = pos_reg;
                        last_next  = pos_reg;
                        mode_next  = is_quote ? MODE_QUOTED : MODE_PLAIN;
                    end
                end
                MODE_PLAIN:
                begin
                    if (is_comma)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else
                    begin
                        if (!is_space)
                        begin
                            last_next = pos_reg;
                        end
                        if (is_quote)
                        begin
                            mode_next = MODE_QUOTED;
                        end
                    end
                end
                MODE_QUOTED:
                begin
                    if (!is_space)
                    begin
                        last_next = pos_reg;
                    end
                    if (is_bslash)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (is_quote)
                    begin
                        mode_next = MODE_PLAIN;
                    end
                end
                default:
                begin
                    if (!is_space)
                    begin
                        last_next = pos_reg;
                    end
                    mode_next = MODE_QUOTED;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BETWEEN;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Field bounds, loaded on every advance; they change only when a field opens or grows
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

endmodule : qft_scan

`default_nettype wire

// File: rtl/qft_out_stage.sv
// Result register: hold one result item until the consumer takes it.
`default_nettype none

module qft_out_stage
    import qft_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_load,
    input  wire qft_result_t       res,
    output logic                   out_free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [FIELD_BITS-1:0]  field_start,
    output logic [FIELD_BITS-1:0]  field_length,
    output logic                   text_done,
    output logic                   position_overflow
);

    logic        valid_reg;
    logic        valid_next;
    qft_result_t res_reg;

    // Slot is free when empty or being taken this cycle
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = res_load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = valid_reg;
    assign field_start       = res_reg.field_start;
    assign field_length      = res_reg.field_length;
    assign text_done         = res_reg.text_done;
    assign position_overflow = res_reg.position_overflow;

endmodule : qft_out_stage

`default_nettype wire

// File: rtl/quoted_field_tokenizer_top.sv
// Top level of the quoted field tokenizer: input register, scanner, result register.
// A result item passes from the input register through the scanner into the result register.
// One item per cycle, unless a byte that yields a result waits on a full result register.
// A byte that yields no result never waits on the result register.
// Reset (rst_n, async, active low) empties both registers and sets the scanner to
// between fields at position 0 with the overflow flag clear.
`default_nettype none

module quoted_field_tokenizer_top
    import qft_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  end_of_text,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic [FIELD_BITS-1:0]      field_start,
    output logic [FIELD_BITS-1:0]      field_length,
    output logic                       text_done,
    output logic                       position_overflow,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    logic        advance;
    logic        item_valid;
    qft_item_t   item;
    logic        out_free;
    logic        res_load;
    qft_result_t res;

    qft_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    qft_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .advance    (advance),
        .res_load   (res_load),
        .res        (res)
    );

    qft_out_stage u_out_stage (
        .clk               (clk),
        .rst_n             (rst_n),
        .res_load          (res_load),
        .res               (res),
        .out_free          (out_free),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .field_start       (field_start),
        .field_length      (field_length),
        .text_done         (text_done),
        .position_overflow (position_overflow)
    );

endmodule : quoted_field_tokenizer_top

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the quoted field tokenizer: directed and random byte streams.
`timescale 1ns / 100ps

module tb;
    import qft_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [7:0]            text_byte = 8'h00;
    logic                  end_of_text = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [FIELD_BITS-1:0] field_start;
    logic [FIELD_BITS-1:0] field_length;
    logic                  text_done;
    logic                  position_overflow;
    logic                  out_valid;
    logic                  out_ready = 1'b0;

    // Fields the scanner should still report, oldest first
    qft_result_t expected_fields[$];
    int          mismatches = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    // Scanner state as the stream has left it
    logic [1:0]          scan_state = MODE_BETWEEN;
    logic [POS_BITS-1:0] next_offset = '0;
    logic [POS_BITS-1:0] field_open_at = '0;
    logic [POS_BITS-1:0] last_visible_at = '0;
    logic                saturated = 1'b0;

    quoted_field_tokenizer_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .text_byte         (text_byte),
        .end_of_text       (end_of_text),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .field_start       (field_start),
        .field_length      (field_length),
        .text_done         (text_done),
        .position_overflow (position_overflow),
        .out_valid         (out_valid),
        .out_ready         (out_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Length of the open field with trailing spaces dropped, saturated
    function automatic logic [FIELD_BITS-1:0] trimmed_length();
        longint span;
        if (last_visible_at < field_open_at)
            span = 0;
        else
            span = longint'(last_visible_at) - longint'(field_open_at) + 1;
        if (span > longint'(POS_MAX))
            span = longint'(POS_MAX);
        return span[FIELD_BITS-1:0];
    endfunction

    // Advance the scanner by one byte and queue the field it closes, if any
    task automatic tokenize_byte(input logic [7:0] b, input logic eot);
        logic [POS_BITS-1:0] at;
        qft_result_t         res;
        if (eot)
        begin
            res.text_done         = 1'b1;
            res.position_overflow = saturated;
            if (scan_state != MODE_BETWEEN)
            begin
                res.field_start  = field_open_at;
                res.field_length = trimmed_length();
            end
            else
            begin
                res.field_start  = '0;
                res.field_length = '0;
            end
            expected_fields.push_back(res);
            scan_state  = MODE_BETWEEN;
            next_offset = '0;
            saturated   = 1'b0;
            return;
        end

        // Hold the offset at the counter limit once reached
        at = next_offset;
        if (next_offset == POS_MAX)
            saturated = 1'b1;
        else
            next_offset = next_offset + 1'b1;

        case (scan_state)
            MODE_BETWEEN:
            begin
                if (b != CH_SPACE && b != CH_COMMA)
                begin
                    field_open_at   = at;
                    last_visible_at = at;
                    scan_state      = (b == CH_QUOTE) ? MODE_QUOTED : MODE_PLAIN;
                end
            end
            MODE_PLAIN:
            begin
                if (b == CH_COMMA)
                begin
                    res.field_start       = field_open_at;
                    res.field_length      = trimmed_length();
                    res.text_done         = 1'b0;
                    res.position_overflow = saturated;
                    expected_fields.push_back(res);
                    scan_state = MODE_BETWEEN;
                end
                else
                begin
                    if (b != CH_SPACE)
                        last_visible_at = at;
                    if (b == CH_QUOTE)
                        scan_state = MODE_QUOTED;
                end
            end
            MODE_QUOTED:
            begin
                if (b != CH_SPACE)
                    last_visible_at = at;
                if (b == CH_BSLASH)
                    scan_state = MODE_ESCAPE;
                else if (b == CH_QUOTE)
                    scan_state = MODE_PLAIN;
            end
            default:
            begin
                if (b != CH_SPACE)
                    last_visible_at = at;
                scan_state = MODE_QUOTED;
            end
        endcase
    endtask

    // Predict on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tokenize_byte(text_byte, end_of_text);
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (!idle_on)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        qft_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fields.size() == 0)
            begin
                $display("%0t: unexpected result start %0d length %0d done %0b ovf %0b",
                         $time, field_start, field_length, text_done, position_overflow);
                mismatches++;
            end
            else
            begin
                want = expected_fields.pop_front();
                compare_field("field_start", want.field_start, field_start);
                compare_field("field_length", want.field_length, field_length);
                compare_field("text_done", want.text_done, text_done);
                compare_field("position_overflow", want.position_overflow,
                              position_overflow);
            end
        end
    end

    // Offer one item, after an optional gap, and hold it until accepted
    task automatic send_item(input logic [7:0] b, input logic eot);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send a whole text followed by its terminator
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    // Mostly letters, with separators, quotes, escapes and arbitrary bytes mixed in
    function automatic logic [7:0] content_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 60)
            return CH_SPACE;
        else if (r < 68)
            return CH_COMMA;
        else if (r < 75)
            return CH_QUOTE;
        else if (r < 80)
            return CH_BSLASH;
        return 8'($urandom);
    endfunction

    // Terminator with nothing open, then a text of separators only
    task automatic test_bare_end();
        send_item(8'hFF, 1'b1);
        send_text(",");
    endtask

    // Zero and all-ones bytes as field content, trailing space trimmed
    task automatic test_plain_fields();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text(" ,b");
    endtask

    // Escaped quote and comma inside quotes, then a closing quote and trim
    task automatic test_quoted_fields();
        send_text("\"a\\\",\" ,");
    endtask

    // Escaped space left open at the end, and a bare backslash before the end
    task automatic test_escapes_at_end();
        send_text("\"\\ ");
        send_text("q\\");
    endtask

    // Random texts built from fields, with some pure noise texts
    task automatic test_random_texts();
        logic [7:0] text_q[$];
        int         sent;
        int         nfields;
        sent = 0;
        while (sent < 650)
        begin
            text_q.delete();
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(0, 16)) text_q.push_back(content_byte());
            end
            else
            begin
                nfields = $urandom_range(0, 4);
                for (int f = 0; f < nfields; f++)
                begin
                    repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        text_q.push_back(CH_QUOTE);
                        repeat ($urandom_range(0, 6))
                        begin
                            if ($urandom_range(0, 4) == 0)
                                text_q.push_back(CH_BSLASH);
                            text_q.push_back(content_byte());
                        end
                        if ($urandom_range(0, 4) != 0)
                            text_q.push_back(CH_QUOTE);
                    end
                    repeat ($urandom_range(0, 5)) text_q.push_back(content_byte());
                    repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
                    if (f != nfields - 1 || $urandom_range(0, 1) == 1)
                        text_q.push_back(CH_COMMA);
                end
            end
            foreach (text_q[i])
                send_item(text_q[i], 1'b0);
            send_item(8'($urandom), 1'b1);
            sent += text_q.size() + 1;
        end
    endtask

    // Run one field past the counter limit, then check the flag clears
    task automatic test_position_saturation();
        idle_on = 1'b0;
        send_item(8'h61, 1'b0);
        repeat (int'(POS_MAX) + 5)
            send_item(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
        send_text(",z,");
        send_text("k");
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bare_end();
        test_plain_fields();
        test_quoted_fields();
        test_escapes_at_end();
        test_random_texts();
        test_position_saturation();
        in_valid <= 1'b0;

        // Drain, then give the pipeline time to show stray results
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_fields.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
